// ----- hw/rtl/lorawan_payload_ctr_cipher_assert.svh -----
// assertion macros used by the checker file
`ifndef LORAWAN_PAYLOAD_CTR_CIPHER_ASSERT_SVH
`define LORAWAN_PAYLOAD_CTR_CIPHER_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define LPC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication checked outside reset
`define LPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- hw/rtl/lpc_pkg.sv -----
// package with types, constants and aes helper functions for the payload cipher
package lpc_pkg;
	localparam int unsigned QueueDepth = 4;
	localparam logic [7:0] BlockTag = 8'h01;

	typedef enum logic [2:0] {
		CFG_NET_HI = 3'd0,
		CFG_NET_LO = 3'd1,
		CFG_APP_HI = 3'd2,
		CFG_APP_LO = 3'd3,
		CFG_DEVADDR = 3'd4,
		CFG_DIR = 3'd5
	} cfg_idx_t;

	// classified byte handed from front to back
	typedef struct packed {
		logic [7:0] data;
		logic last;
		logic new_block;
		logic [3:0] pos;
		logic [7:0] block_num;
		logic [31:0] fcnt;
		logic use_net;
	} cmd_t;

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[x];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// state byte i sits at bits 127-8i .. 120-8i
	function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
		input logic final_rnd);
		logic [7:0] b [16];
		logic [7:0] t [16];
		logic [7:0] m [16];
		logic [7:0] x;
		logic [127:0] o;
		for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
		for (int c = 0; c < 4; c++)
			for (int i = 0; i < 4; i++)
				t[i+4*c] = sbox(b[i + 4*((c+i) % 4)]);
		for (int c = 0; c < 4; c++) begin
			x = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
			m[4*c] = t[4*c] ^ x ^ xtime(t[4*c] ^ t[4*c+1]);
			m[4*c+1] = t[4*c+1] ^ x ^ xtime(t[4*c+1] ^ t[4*c+2]);
			m[4*c+2] = t[4*c+2] ^ x ^ xtime(t[4*c+2] ^ t[4*c+3]);
			m[4*c+3] = t[4*c+3] ^ x ^ xtime(t[4*c+3] ^ t[4*c]);
		end
		for (int i = 0; i < 16; i++) o[127-8*i -: 8] = final_rnd ? t[i] : m[i];
		return o ^ rk;
	endfunction

	function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3, t;
		{w0, w1, w2, w3} = k;
		t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
		w0 = w0 ^ t;
		w1 = w1 ^ w0;
		w2 = w2 ^ w1;
		w3 = w3 ^ w2;
		return {w0, w1, w2, w3};
	endfunction
endpackage

// ----- hw/rtl/lorawan_payload_ctr_cipher.sv -----
// top level of the frame payload aes-128 counter mode cipher
// usage:
//  s_axis carries one plaintext byte per item with tuser {first, frame_count, port} marks
//  and tlast on the last byte of a payload; m_axis returns one ciphertext byte per
//  item with tlast copied from the input.
//  cfg channel writes session keys, device address and direction by index; write
//  only while no item is in flight.
//  a front stage tracks position in the 16-byte block and tags each item with its
//  block index, frame counter and key choice; a 4-entry queue decouples it from the
//  back end.
//  the back end runs one aes round per cycle: a byte that opens a block waits for
//  the round loop to build its keystream, and no byte is passed on while the loop
//  runs; other bytes are xored with the held keystream without waiting.
//  a mid-block byte is registered in the queue and then in the output register.
//  reset clears position, block and held frame counters, key choice and control state.
//  a stalled receiver holds the output register; the queue fills and then tready drops.
module lorawan_payload_ctr_cipher (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata,   // payload_byte
	input  logic s_tlast,         // last_byte
	input  logic [40:0] s_tuser,  // first_byte, frame_count[31:0], port[7:0]
	output logic m_tvalid,
	input  logic m_tready,
	output logic [7:0] m_tdata,   // cipher_byte
	output logic m_tlast,         // end_of_payload
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [63:0] cfg_data
);
	logic [63:0] net_hi_q, net_lo_q, app_hi_q, app_lo_q;
	logic [31:0] dev_q;
	logic dir_q;
	logic fq_valid, fq_ready, qb_valid, qb_ready;
	lpc_pkg::cmd_t fq_cmd, qb_cmd;

	assign cfg_ready = 1'b1;

	// configuration register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			net_hi_q <= '0;
			net_lo_q <= '0;
			app_hi_q <= '0;
			app_lo_q <= '0;
			dev_q <= '0;
			dir_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				lpc_pkg::CFG_NET_HI: net_hi_q <= cfg_data;
				lpc_pkg::CFG_NET_LO: net_lo_q <= cfg_data;
				lpc_pkg::CFG_APP_HI: app_hi_q <= cfg_data;
				lpc_pkg::CFG_APP_LO: app_lo_q <= cfg_data;
				lpc_pkg::CFG_DEVADDR: dev_q <= cfg_data[31:0];
				lpc_pkg::CFG_DIR: dir_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	lpc_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.payload_byte(s_tdata), .first_byte(s_tuser[0]), .last_byte(s_tlast),
		.frame_count(s_tuser[32:1]), .port(s_tuser[40:33]),
		.cmd_valid(fq_valid), .cmd_ready(fq_ready), .cmd(fq_cmd)
	);

	lpc_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_cmd),
		.rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_cmd)
	);

	lpc_back u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(qb_valid), .cmd_ready(qb_ready), .cmd(qb_cmd),
		.net_key({net_hi_q, net_lo_q}), .app_key({app_hi_q, app_lo_q}),
		.node_addr(dev_q), .dir(dir_q),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.cipher_byte(m_tdata), .end_of_payload(m_tlast)
	);
endmodule

// ----- hw/rtl/lpc_front.sv -----
// front end: tracks payload position and classifies each byte
module lpc_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] payload_byte,
	input  logic first_byte,
	input  logic last_byte,
	input  logic [31:0] frame_count,
	input  logic [7:0] port,
	output logic cmd_valid,
	input  logic cmd_ready,
	output lpc_pkg::cmd_t cmd
);
	logic [3:0] pos_q;
	logic [7:0] blk_q;
	logic [31:0] fcnt_q;
	logic use_net_q;
	logic [3:0] pos;
	logic [7:0] blk;

	assign in_ready = cmd_ready;
	assign cmd_valid = in_valid;
	assign pos = first_byte ? 4'd0 : pos_q;
	assign blk = (first_byte ? 8'd0 : blk_q) + ((pos == 4'd0) ? 8'd1 : 8'd0);

	always_comb begin
		cmd.data = payload_byte;
		cmd.last = last_byte;
		cmd.new_block = (pos == 4'd0);
		cmd.pos = pos;
		cmd.block_num = blk;
		cmd.fcnt = first_byte ? frame_count : fcnt_q;
		cmd.use_net = first_byte ? (port == 8'd0) : use_net_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			blk_q <= '0;
			fcnt_q <= '0;
			use_net_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			fcnt_q <= cmd.fcnt;
			use_net_q <= cmd.use_net;
			pos_q <= last_byte ? 4'd0 : pos + 4'd1;
			blk_q <= last_byte ? 8'd0 : blk;
		end
	end
endmodule

// ----- hw/rtl/lpc_queue.sv -----
// small fifo between front and back
module lpc_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  lpc_pkg::cmd_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output lpc_pkg::cmd_t rd_data
);
	localparam int unsigned AW = $clog2(lpc_pkg::QueueDepth);
	lpc_pkg::cmd_t mem_q [lpc_pkg::QueueDepth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic wr, rd;

	assign wr_ready = (cnt_q != AW'(0) + (AW+1)'(lpc_pkg::QueueDepth));
	assign rd_valid = (cnt_q != '0);
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + AW'(1);
			if (rd) rp_q <= rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end
endmodule

// ----- hw/rtl/lpc_back.sv -----
// back end: round-per-cycle aes keystream and byte xor with output register
module lpc_back (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  lpc_pkg::cmd_t cmd,
	input  logic [127:0] net_key,
	input  logic [127:0] app_key,
	input  logic [31:0] node_addr,
	input  logic dir,
	output logic out_valid,
	input  logic out_ready,
	output logic [7:0] cipher_byte,
	output logic end_of_payload
);
	logic busy_q;
	logic [3:0] rnd_q;
	logic [127:0] st_q, rk_q, ks_q;
	logic [7:0] rc_q;
	logic [127:0] key, blk, nxt_rk;
	logic ov_q;
	logic [7:0] cb_q;
	logic eop_q;
	logic ks_pending_q;
	logic slot, start, emit;

	assign key = cmd.use_net ? net_key : app_key;
	assign blk = {lpc_pkg::BlockTag, 32'd0, 7'd0, dir,
		node_addr[7:0], node_addr[15:8], node_addr[23:16], node_addr[31:24],
		cmd.fcnt[7:0], cmd.fcnt[15:8], cmd.fcnt[23:16], cmd.fcnt[31:24],
		8'd0, cmd.block_num};
	assign nxt_rk = lpc_pkg::key_step(rk_q, rc_q);
	assign slot = !ov_q || out_ready;
	assign start = cmd_valid && cmd.new_block && !busy_q && !ks_pending_q;
	assign emit = cmd_valid && slot && !busy_q && (!cmd.new_block || ks_pending_q);
	assign cmd_ready = emit;

	always_ff @(posedge clk) begin
		if (start) begin
			st_q <= blk ^ key;
			rk_q <= key;
		end else if (busy_q) begin
			st_q <= lpc_pkg::aes_round(st_q, nxt_rk, rnd_q == 4'd10);
			rk_q <= nxt_rk;
			if (rnd_q == 4'd10) ks_q <= lpc_pkg::aes_round(st_q, nxt_rk, 1'b1);
		end
		if (emit) begin
			cb_q <= cmd.data ^ ks_q[127 - 8*cmd.pos -: 8];
			eop_q <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q <= '0;
			rc_q <= '0;
			ks_pending_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				rnd_q <= 4'd1;
				rc_q <= 8'h01;
			end else if (busy_q) begin
				rc_q <= lpc_pkg::xtime(rc_q);
				rnd_q <= rnd_q + 4'd1;
				if (rnd_q == 4'd10) begin
					busy_q <= 1'b0;
					ks_pending_q <= 1'b1;
				end
			end
			if (emit && cmd.new_block) ks_pending_q <= 1'b0;
			if (emit) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	assign out_valid = ov_q;
	assign cipher_byte = cb_q;
	assign end_of_payload = eop_q;
endmodule

// ----- hw/rtl/lpc_checker.sv -----
// port-level checker bound to the cipher top level
`include "lorawan_payload_ctr_cipher_assert.svh"
module lpc_checker (
	input logic clk,
	input logic arst_n,
	input logic m_tvalid,
	input logic m_tready,
	input logic [7:0] m_tdata,
	input logic m_tlast,
	input logic cfg_ready
);
	logic [8:0] beat;

	assign beat = {m_tlast, m_tdata};

	`LPC_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "output dropped while stalled")
	`LPC_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(beat), "stalled output changed")
	`LPC_ASSERT_IMP(a_cfg_ready, 1'b1, cfg_ready, "config port not ready")
endmodule

bind lorawan_payload_ctr_cipher lpc_checker u_checker (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata), .m_tlast(m_tlast), .cfg_ready(cfg_ready)
);
